// File: rtl/area_bounded_resolution_planner_defines.svh
// Assertion macros for the resolution planner.
// Each macro ends in its own semicolon; write one use on a line.
`ifndef AREA_BOUNDED_RESOLUTION_PLANNER_DEFINES_SVH
`define AREA_BOUNDED_RESOLUTION_PLANNER_DEFINES_SVH
`ifndef SYNTH
// The property must hold at every clock edge out of reset.
`define ABRP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("abrp assertion failed");
// The condition must never be true out of reset.
`define ABRP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("abrp forbidden condition seen");
`else
`define ABRP_ASSERT(label, clk, rst_n, prop)
`define ABRP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/abrp_pkg.sv
// ----------------------------------------------------------------------------
// abrp_pkg
// Shared widths, defaults, status codes and job tags of the resolution planner.
// ----------------------------------------------------------------------------
package abrp_pkg;

	localparam int ALIGN_STEP_DEF = 16;
	localparam int SIDE_BITS_DEF  = 16;

	localparam int BUDGET_W = 32;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd1048576;

	localparam int REQ_W    = 16;
	localparam int STATUS_W = 3;
	localparam int SCALED_W = 16;
	localparam int CROP_W   = 4;
	localparam int HALF_W   = 13;
	localparam int GRID_W   = 12;
	localparam int TOKEN_W  = 24;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NONPOS     = 3'd1,
		ST_ALIGN_ZERO = 3'd2,
		ST_NOT_MULT   = 3'd3,
		ST_OVERFLOW   = 3'd4
	} abrp_status_t;

	// Classification made by the front end for one job.
	typedef struct packed {
		logic         area;
		abrp_status_t status;
	} abrp_meta_t;

endpackage

// File: rtl/abrp_if.sv
// ----------------------------------------------------------------------------
// abrp_if
// Valid/ready channels of the planner: request beats in, plan beats out.
// ----------------------------------------------------------------------------
interface abrp_req_if;
	import abrp_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic [REQ_W-1:0] req_rows;
	logic [REQ_W-1:0] req_cols;
	modport source (output valid, mode, req_rows, req_cols, input ready);
	modport sink   (input valid, mode, req_rows, req_cols, output ready);
endinterface

interface abrp_rsp_if;
	import abrp_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status_code;
	logic [SCALED_W-1:0] scaled_rows;
	logic [SCALED_W-1:0] scaled_cols;
	logic [SCALED_W-1:0] aligned_rows;
	logic [SCALED_W-1:0] aligned_cols;
	logic [CROP_W-1:0]   crop_row_offset;
	logic [CROP_W-1:0]   crop_col_offset;
	logic [HALF_W-1:0]   half_res_rows;
	logic [HALF_W-1:0]   half_res_cols;
	logic [GRID_W-1:0]   grid_rows;
	logic [GRID_W-1:0]   grid_cols;
	logic [TOKEN_W-1:0]  token_count;
	modport source (output valid, status_code, scaled_rows, scaled_cols, aligned_rows,
		aligned_cols, crop_row_offset, crop_col_offset, half_res_rows, half_res_cols,
		grid_rows, grid_cols, token_count, input ready);
	modport sink (input valid, status_code, scaled_rows, scaled_cols, aligned_rows,
		aligned_cols, crop_row_offset, crop_col_offset, half_res_rows, half_res_cols,
		grid_rows, grid_cols, token_count, output ready);
endinterface

// File: rtl/abrp_front.sv
// ----------------------------------------------------------------------------
// abrp_front
// Holds the area budget, classifies requests and forms budget*side products.
// ----------------------------------------------------------------------------
module abrp_front #(
	parameter int SIDE_BITS = abrp_pkg::SIDE_BITS_DEF,
	parameter int NW        = 32 + SIDE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [abrp_pkg::BUDGET_W-1:0]    cfg_wdata,
	abrp_req_if.sink                         req,
	input  logic                             q_full,
	output logic                             push,
	output abrp_pkg::abrp_meta_t             job_meta,
	output logic [SIDE_BITS-1:0]             job_rows,
	output logic [SIDE_BITS-1:0]             job_cols,
	output logic [NW-1:0]                    job_num_r,
	output logic [NW-1:0]                    job_num_c
);
	import abrp_pkg::*;

	logic [BUDGET_W-1:0]  budget_q;
	logic [SIDE_BITS-1:0] rows_m;
	logic [SIDE_BITS-1:0] cols_m;
	logic                 side_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	assign rows_m    = SIDE_BITS'(req.req_rows);
	assign cols_m    = SIDE_BITS'(req.req_cols);
	assign side_zero = (rows_m == '0) || (cols_m == '0);

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		job_meta.area   = 1'b0;
		job_meta.status = ST_OK;
		if (req.mode) begin
			if (side_zero || (budget_q == '0)) begin
				job_meta.status = ST_NONPOS;
			end else begin
				job_meta.area = 1'b1;
			end
		end else if (side_zero) begin
			job_meta.status = ST_NONPOS;
		end
	end

	assign job_rows  = rows_m;
	assign job_cols  = cols_m;
	assign job_num_r = NW'(budget_q) * NW'(rows_m);
	assign job_num_c = NW'(budget_q) * NW'(cols_m);

endmodule

// File: rtl/abrp_queue.sv
// ----------------------------------------------------------------------------
// abrp_queue
// Small register FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "area_bounded_resolution_planner_defines.svh"
module abrp_queue #(
	parameter int W     = 8,
	parameter int DEPTH = abrp_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ABRP_ASSERT_NEVER(a_cnt_over, clk, arst_n, cnt_q > CW'(DEPTH))
	`ABRP_ASSERT(a_cnt_up, clk, arst_n, (wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
	`ABRP_ASSERT(a_cnt_dn, clk, arst_n, (rd && !wr) |=> (cnt_q == $past(cnt_q) - 1'b1))

endmodule

// File: rtl/abrp_root.sv
// ----------------------------------------------------------------------------
// abrp_root
// Pipelined round-half-even of sqrt(num/den): restoring divider, one quotient
// bit per stage, then restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module abrp_root #(
	parameter int SIDE_BITS = abrp_pkg::SIDE_BITS_DEF,
	parameter int NW        = 32 + SIDE_BITS,
	parameter int RW        = (NW + 1) / 2
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NW-1:0]        num,
	input  logic [SIDE_BITS-1:0] den,
	output logic [RW:0]          res
);
	localparam int SW = SIDE_BITS;
	localparam int QW = 2 * RW;

	logic [SW-1:0]   dr_q [NW];
	logic [NW-1:0]   dw_q [NW];
	logic [SW-1:0]   dd_q [NW];

	logic [RW-1:0]   sroot_q [RW];
	logic [RW+1:0]   srem_q  [RW];
	logic [QW-1:0]   sq_q    [RW];
	logic [SW-1:0]   sdr_q   [RW];
	logic [SW-1:0]   sdd_q   [RW];

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [SW-1:0] rem_in;
		logic [NW-1:0] w_in;
		logic [SW-1:0] den_in;
		logic [SW:0]   t;
		logic          ge;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign w_in   = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = dr_q[i-1];
			assign w_in   = dw_q[i-1];
			assign den_in = dd_q[i-1];
		end
		assign t  = {rem_in, w_in[NW-1]};
		assign ge = (t >= {1'b0, den_in});
		always_ff @(posedge clk) begin
			if (en) begin
				dr_q[i] <= ge ? SW'(t - {1'b0, den_in}) : t[SW-1:0];
				dw_q[i] <= {w_in[NW-2:0], ge};
				dd_q[i] <= den_in;
			end
		end
	end

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		logic [RW-1:0] root_in;
		logic [RW+1:0] rem_in;
		logic [QW-1:0] q_in;
		logic [SW-1:0] dr_in;
		logic [SW-1:0] dd_in;
		logic [RW+3:0] rem2;
		logic [RW+3:0] trial;
		logic          ge;
		if (j == 0) begin : g_first
			assign root_in = '0;
			assign rem_in  = '0;
			assign q_in    = QW'(dw_q[NW-1]);
			assign dr_in   = dr_q[NW-1];
			assign dd_in   = dd_q[NW-1];
		end else begin : g_next
			assign root_in = sroot_q[j-1];
			assign rem_in  = srem_q[j-1];
			assign q_in    = sq_q[j-1];
			assign dr_in   = sdr_q[j-1];
			assign dd_in   = sdd_q[j-1];
		end
		assign rem2  = {rem_in, q_in[QW-1:QW-2]};
		assign trial = (RW+4)'({root_in, 2'b01});
		assign ge    = (rem2 >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				sroot_q[j] <= {root_in[RW-2:0], ge};
				srem_q[j]  <= ge ? (RW+2)'(rem2 - trial) : rem2[RW+1:0];
				sq_q[j]    <= {q_in[QW-3:0], 2'b00};
				sdr_q[j]   <= dr_in;
				sdd_q[j]   <= dd_in;
			end
		end
	end

	// sqrt remainder against root decides unless equal; then 4*rem against den.
	logic [RW-1:0]   r;
	logic [RW+1:0]   sr;
	logic [SW+1:0]   four_rem;
	logic [SW+1:0]   den_x;
	logic            up;

	assign r        = sroot_q[RW-1];
	assign sr       = srem_q[RW-1];
	assign four_rem = {sdr_q[RW-1], 2'b00};
	assign den_x    = {2'b00, sdd_q[RW-1]};

	always_comb begin
		if (sr > {2'b00, r}) begin
			up = 1'b1;
		end else if (sr < {2'b00, r}) begin
			up = 1'b0;
		end else if (four_rem > den_x) begin
			up = 1'b1;
		end else if (four_rem < den_x) begin
			up = 1'b0;
		end else begin
			up = r[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= (RW+1)'(r) + (RW+1)'(up);
		end
	end

endmodule

// File: rtl/abrp_back.sv
// ----------------------------------------------------------------------------
// abrp_back
// Runs queued jobs through the two root units, aligns, and forms the plan.
// ----------------------------------------------------------------------------
module abrp_back #(
	parameter int SIDE_BITS  = abrp_pkg::SIDE_BITS_DEF,
	parameter int ALIGN_STEP = abrp_pkg::ALIGN_STEP_DEF,
	parameter int NW         = 32 + SIDE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	output logic                 q_pop,
	input  abrp_pkg::abrp_meta_t job_meta,
	input  logic [SIDE_BITS-1:0] job_rows,
	input  logic [SIDE_BITS-1:0] job_cols,
	input  logic [NW-1:0]        job_num_r,
	input  logic [NW-1:0]        job_num_c,
	abrp_rsp_if.source           rsp
);
	import abrp_pkg::*;

	localparam int SW  = SIDE_BITS;
	localparam int RW  = (NW + 1) / 2;
	localparam int LAT = NW + RW + 1;
	localparam int AW  = $clog2(ALIGN_STEP);
	localparam int K   = SW + AW;
	localparam int MW  = SW + 1;
	localparam int PW  = SW + MW;
	localparam longint unsigned MUL_L =
		((64'd1 << K) + longint'(ALIGN_STEP) - 1) / longint'(ALIGN_STEP);
	localparam logic [MW-1:0] MUL = MW'(MUL_L);

	logic adv;
	assign adv   = !rsp.valid || rsp.ready;
	assign q_pop = adv && !q_empty;

	logic [RW:0] res_r;
	logic [RW:0] res_c;

	abrp_root #(.SIDE_BITS(SW), .NW(NW), .RW(RW)) u_root_r (
		.clk(clk), .en(adv), .num(job_num_r), .den(job_cols), .res(res_r)
	);
	abrp_root #(.SIDE_BITS(SW), .NW(NW), .RW(RW)) u_root_c (
		.clk(clk), .en(adv), .num(job_num_c), .den(job_rows), .res(res_c)
	);

	// Job tags ride alongside the root units.
	logic          ln_vld_q  [LAT];
	abrp_meta_t    ln_meta_q [LAT];
	logic [SW-1:0] ln_rows_q [LAT];
	logic [SW-1:0] ln_cols_q [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				ln_vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			ln_vld_q[0] <= q_pop;
			for (int k = 1; k < LAT; k++) begin
				ln_vld_q[k] <= ln_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_meta_q[0] <= job_meta;
			ln_rows_q[0] <= job_rows;
			ln_cols_q[0] <= job_cols;
			for (int k = 1; k < LAT; k++) begin
				ln_meta_q[k] <= ln_meta_q[k-1];
				ln_rows_q[k] <= ln_rows_q[k-1];
				ln_cols_q[k] <= ln_cols_q[k-1];
			end
		end
	end

	// Stage 1: pick the side, flag overflow, reciprocal divide by the step.
	abrp_meta_t    m_in;
	logic [RW:0]   full_r;
	logic [RW:0]   full_c;
	logic [SW-1:0] s_r;
	logic [SW-1:0] s_c;
	logic [PW-1:0] prod_r;
	logic [PW-1:0] prod_c;
	logic          ovf;

	assign m_in   = ln_meta_q[LAT-1];
	assign full_r = m_in.area ? res_r : (RW+1)'(ln_rows_q[LAT-1]);
	assign full_c = m_in.area ? res_c : (RW+1)'(ln_cols_q[LAT-1]);
	assign ovf    = m_in.area && ((|full_r[RW:SW]) || (|full_c[RW:SW]));
	assign s_r    = full_r[SW-1:0];
	assign s_c    = full_c[SW-1:0];
	assign prod_r = PW'(s_r) * PW'(MUL);
	assign prod_c = PW'(s_c) * PW'(MUL);

	logic          vld_s1;
	abrp_meta_t    meta_s1;
	logic          ovf_s1;
	logic [SW-1:0] s_r_s1;
	logic [SW-1:0] s_c_s1;
	logic [SW-1:0] g_r_s1;
	logic [SW-1:0] g_c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ln_vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= m_in;
			ovf_s1  <= ovf;
			s_r_s1  <= s_r;
			s_c_s1  <= s_c;
			g_r_s1  <= prod_r[K +: SW];
			g_c_s1  <= prod_c[K +: SW];
		end
	end

	// Stage 2: aligned size, excess, crop, status and token count.
	logic [SW-1:0]      a_r;
	logic [SW-1:0]      a_c;
	logic [SW-1:0]      e_r;
	logic [SW-1:0]      e_c;
	logic [SW-1:0]      h_r;
	logic [SW-1:0]      h_c;
	logic [GRID_W-1:0]  gr;
	logic [GRID_W-1:0]  gc;
	abrp_status_t       st;

	assign a_r = SW'(g_r_s1 * SW'(ALIGN_STEP));
	assign a_c = SW'(g_c_s1 * SW'(ALIGN_STEP));
	assign e_r = s_r_s1 - a_r;
	assign e_c = s_c_s1 - a_c;
	assign h_r = (e_r >> 1) + SW'(e_r[0] && e_r[1]);
	assign h_c = (e_c >> 1) + SW'(e_c[0] && e_c[1]);
	assign gr  = GRID_W'(g_r_s1);
	assign gc  = GRID_W'(g_c_s1);

	always_comb begin
		if (meta_s1.status != ST_OK) begin
			st = meta_s1.status;
		end else if (meta_s1.area) begin
			if (ovf_s1) begin
				st = ST_OVERFLOW;
			end else if ((a_r == '0) || (a_c == '0)) begin
				st = ST_ALIGN_ZERO;
			end else begin
				st = ST_OK;
			end
		end else if ((e_r != '0) || (e_c != '0)) begin
			st = ST_NOT_MULT;
		end else begin
			st = ST_OK;
		end
	end

	logic               out_vld_q;
	abrp_status_t       st_q;
	logic [SCALED_W-1:0] sr_q, sc_q, ar_q, ac_q;
	logic [CROP_W-1:0]   cr_q, cc_q;
	logic [HALF_W-1:0]   hr_q, hc_q;
	logic [GRID_W-1:0]   gr_q, gc_q;
	logic [TOKEN_W-1:0]  tk_q;
	logic                ok;

	assign ok = (st == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= st;
			sr_q <= ok ? SCALED_W'(s_r_s1) : '0;
			sc_q <= ok ? SCALED_W'(s_c_s1) : '0;
			ar_q <= ok ? SCALED_W'(a_r) : '0;
			ac_q <= ok ? SCALED_W'(a_c) : '0;
			cr_q <= ok ? CROP_W'(h_r) : '0;
			cc_q <= ok ? CROP_W'(h_c) : '0;
			hr_q <= ok ? HALF_W'(a_r >> 3) : '0;
			hc_q <= ok ? HALF_W'(a_c >> 3) : '0;
			gr_q <= ok ? gr : '0;
			gc_q <= ok ? gc : '0;
			tk_q <= ok ? TOKEN_W'(TOKEN_W'(gr) * TOKEN_W'(gc)) : '0;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status_code     = st_q;
	assign rsp.scaled_rows     = sr_q;
	assign rsp.scaled_cols     = sc_q;
	assign rsp.aligned_rows    = ar_q;
	assign rsp.aligned_cols    = ac_q;
	assign rsp.crop_row_offset = cr_q;
	assign rsp.crop_col_offset = cc_q;
	assign rsp.half_res_rows   = hr_q;
	assign rsp.half_res_cols   = hc_q;
	assign rsp.grid_rows       = gr_q;
	assign rsp.grid_cols       = gc_q;
	assign rsp.token_count     = tk_q;

endmodule

// File: rtl/area_bounded_resolution_planner.sv
// ----------------------------------------------------------------------------
// area_bounded_resolution_planner
// Plans an aligned frame size from a request, optionally scaled to an area budget.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request beats (mode, req_rows, req_cols), valid/ready.
//   rsp  : one plan beat per request, in order, valid/ready.
//   cfg_we/cfg_wdata : write the area budget; change it only while idle.
// From request beat to plan beat, a job passes the queue, the root units,
// the stage 1 register and the output register. The root units, sized by
// NW = 32 + SIDE_BITS and RW = ceil(NW/2), are a restoring divider giving
// one quotient bit per stage, then a restoring square root giving one root
// bit per stage. Throughput is one request per cycle while the receiver does
// not stall; requests of either mode share the same pipeline, so order is kept.
// Reset clears all valid state and loads the budget with 1048576 pixels.
// When the receiver stalls, the whole back end holds in place; the front
// keeps taking beats into its four-entry queue and drops ready once full.
// ----------------------------------------------------------------------------
module area_bounded_resolution_planner #(
	parameter int ALIGN_STEP = abrp_pkg::ALIGN_STEP_DEF,
	parameter int SIDE_BITS  = abrp_pkg::SIDE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abrp_pkg::BUDGET_W-1:0] cfg_wdata,
	abrp_req_if.sink                      req,
	abrp_rsp_if.source                    rsp
);
	import abrp_pkg::*;

	// Product width of budget times side, and the width of one queue entry.
	localparam int NW    = 32 + SIDE_BITS;
	localparam int META_W = $bits(abrp_meta_t);
	localparam int JOB_W = META_W + 2 * SIDE_BITS + 2 * NW;

	logic                 push;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	abrp_meta_t           enq_meta;
	logic [SIDE_BITS-1:0] enq_rows;
	logic [SIDE_BITS-1:0] enq_cols;
	logic [NW-1:0]        enq_num_r;
	logic [NW-1:0]        enq_num_c;
	logic [JOB_W-1:0]     enq_vec;
	logic [JOB_W-1:0]     deq_vec;
	abrp_meta_t           deq_meta;
	logic [SIDE_BITS-1:0] deq_rows;
	logic [SIDE_BITS-1:0] deq_cols;
	logic [NW-1:0]        deq_num_r;
	logic [NW-1:0]        deq_num_c;

	// Front: hold the budget, classify the request, form both products.
	abrp_front #(.SIDE_BITS(SIDE_BITS), .NW(NW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.job_meta  (enq_meta),
		.job_rows  (enq_rows),
		.job_cols  (enq_cols),
		.job_num_r (enq_num_r),
		.job_num_c (enq_num_c)
	);

	assign enq_vec = {enq_meta, enq_rows, enq_cols, enq_num_r, enq_num_c};

	// Queue: decouple front acceptance from back-end stalls.
	abrp_queue #(.W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.din    (enq_vec),
		.full   (q_full),
		.rd     (q_pop),
		.dout   (deq_vec),
		.empty  (q_empty)
	);

	assign {deq_meta, deq_rows, deq_cols, deq_num_r, deq_num_c} = deq_vec;

	// Back: root units, alignment and the output register.
	abrp_back #(.SIDE_BITS(SIDE_BITS), .ALIGN_STEP(ALIGN_STEP), .NW(NW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.job_meta  (deq_meta),
		.job_rows  (deq_rows),
		.job_cols  (deq_cols),
		.job_num_r (deq_num_r),
		.job_num_c (deq_num_c),
		.rsp       (rsp)
	);

endmodule
